@@ rtl/stt_pkg.sv @@
package stt_pkg;

  // Table geometry.
  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // Command queue between the front and the engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream word widths.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  localparam logic [15:0] RANGE_EMPTY_LO = 16'hffff;
  localparam logic [15:0] RANGE_EMPTY_HI = 16'h0000;

  // Operation codes on the input word.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_REG   = 2'd1;
  localparam logic [1:0] OP_TRANS = 2'd2;

  // Status codes on the result word.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    K_ADD   = 2'd0,
    K_REG   = 2'd1,
    K_TRANS = 2'd2,
    K_NOP   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] segment;
    logic [15:0] offset;
    logic [19:0] linear_address;
  } cmd_t;

  typedef struct packed {
    logic [15:0] seg;
    logic [15:0] lo;
    logic [15:0] hi;
  } entry_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } eng_stat_t;

endpackage

@@ rtl/stt_front.sv @@
module stt_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [stt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [1:0]                        in_tuser,
  output logic                              cmd_valid,
  output stt_pkg::cmd_t                     cmd,
  input  logic                              cmd_pop
);

  stt_pkg::cmd_t                  q_mem [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [stt_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [stt_pkg::QCNT_W-1:0]     fill_r, fill_nxt;
  stt_pkg::cmd_t                  dec;
  logic                           push;
  logic                           pop;

  // Sort the operation code into a command kind; the unused code becomes a no-op.
  always_comb begin
    dec.segment        = in_tdata[15:0];
    dec.offset         = in_tdata[31:16];
    dec.linear_address = in_tdata[51:32];
    case (in_tuser)
      stt_pkg::OP_ADD:   dec.kind = stt_pkg::K_ADD;
      stt_pkg::OP_REG:   dec.kind = stt_pkg::K_REG;
      stt_pkg::OP_TRANS: dec.kind = stt_pkg::K_TRANS;
      default:           dec.kind = stt_pkg::K_NOP;
    endcase
  end

  assign in_tready = (fill_r != stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (fill_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + stt_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + stt_pkg::QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + stt_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - stt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

endmodule

@@ rtl/stt_engine.sv @@
module stt_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  stt_pkg::cmd_t                     cmd,
  output logic                              cmd_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [stt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [1:0]                        out_tuser,
  output stt_pkg::eng_stat_t                stat
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  localparam int IW = stt_pkg::IDX_W;
  localparam int CW = stt_pkg::CNT_W;

  stt_pkg::entry_t mem [stt_pkg::MAX_SEGMENTS];
  stt_pkg::entry_t rdata_r;
  logic [IW-1:0]   rd_addr;
  logic            we;
  logic [IW-1:0]   wa;
  stt_pkg::entry_t wd;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            dvld_r, dvld_nxt;
  logic [IW-1:0]   didx_r, didx_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [IW-1:0]   dst_r, dst_nxt;
  logic [15:0]     found_r, found_nxt;
  stt_pkg::cmd_t   cmd_r, cmd_nxt;

  logic [1:0]      res_status_r, res_status_nxt;
  logic [15:0]     res_seg_r, res_seg_nxt;
  logic [19:0]     res_ofs_r, res_ofs_nxt;
  logic [15:0]     res_lo_r, res_lo_nxt;
  logic [15:0]     res_hi_r, res_hi_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r;
  logic [15:0]     out_seg_r;
  logic [19:0]     out_ofs_r;
  logic [15:0]     out_lo_r;
  logic [15:0]     out_hi_r;
  logic            out_load;

  logic            full;
  logic            issue;
  logic [19:0]     base;
  logic [15:0]     new_lo;
  logic [15:0]     new_hi;

  assign full   = (count_r == CW'(stt_pkg::MAX_SEGMENTS));
  assign base   = {rdata_r.seg, 4'b0000};
  assign new_lo = (cmd_r.offset < rdata_r.lo) ? cmd_r.offset : rdata_r.lo;
  assign new_hi = (cmd_r.offset > rdata_r.hi) ? cmd_r.offset : rdata_r.hi;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    dvld_nxt       = dvld_r;
    didx_nxt       = didx_r;
    pos_nxt        = pos_r;
    dst_nxt        = dst_r;
    found_nxt      = found_r;
    cmd_nxt        = cmd_r;
    res_status_nxt = res_status_r;
    res_seg_nxt    = res_seg_r;
    res_ofs_nxt    = res_ofs_r;
    res_lo_nxt     = res_lo_r;
    res_hi_nxt     = res_hi_r;
    rd_addr        = rd_idx_r[IW-1:0];
    we             = 1'b0;
    wa             = didx_r;
    wd             = rdata_r;
    cmd_pop        = 1'b0;
    out_load       = 1'b0;
    issue          = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cmd_nxt        = cmd;
          rd_idx_nxt     = '0;
          dvld_nxt       = 1'b0;
          found_nxt      = '0;
          res_status_nxt = stt_pkg::ST_DONE;
          res_seg_nxt    = cmd.segment;
          res_ofs_nxt    = '0;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
          if (cmd.kind == stt_pkg::K_NOP) begin
            res_seg_nxt = '0;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Reads stream out one entry a cycle; the compare sees each entry in the cycle after its read.
        issue = (rd_idx_r < count_r);
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          didx_nxt   = rd_idx_r[IW-1:0];
          dvld_nxt   = 1'b1;
        end else begin
          dvld_nxt = 1'b0;
        end

        if (dvld_r) begin
          case (cmd_r.kind)
            stt_pkg::K_ADD: begin
              if (rdata_r.seg >= cmd_r.segment) begin
                dvld_nxt = 1'b0;
                if (rdata_r.seg == cmd_r.segment) begin
                  res_status_nxt = stt_pkg::ST_DUP;
                  state_nxt      = S_DONE;
                end else if (full) begin
                  res_status_nxt = stt_pkg::ST_FULL;
                  state_nxt      = S_DONE;
                end else begin
                  pos_nxt   = didx_r;
                  dst_nxt   = count_r[IW-1:0];
                  state_nxt = S_SHIFT;
                end
              end
            end
            stt_pkg::K_REG: begin
              if (rdata_r.seg == cmd_r.segment) begin
                we         = 1'b1;
                wa         = didx_r;
                wd         = '{seg: rdata_r.seg, lo: new_lo, hi: new_hi};
                res_lo_nxt = new_lo;
                res_hi_nxt = new_hi;
                dvld_nxt   = 1'b0;
                state_nxt  = S_DONE;
              end
            end
            stt_pkg::K_TRANS: begin
              if (base > cmd_r.linear_address) begin
                res_seg_nxt = found_r;
                res_ofs_nxt = cmd_r.linear_address - {found_r, 4'b0000};
                dvld_nxt    = 1'b0;
                state_nxt   = S_DONE;
              end else begin
                found_nxt = rdata_r.seg;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (!issue) begin
          // Walked past the last entry without a stop.
          case (cmd_r.kind)
            stt_pkg::K_ADD: begin
              if (full) begin
                res_status_nxt = stt_pkg::ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                pos_nxt   = count_r[IW-1:0];
                dst_nxt   = count_r[IW-1:0];
                state_nxt = S_SHIFT;
              end
            end
            stt_pkg::K_REG: begin
              res_status_nxt = stt_pkg::ST_UNKNOWN;
              state_nxt      = S_DONE;
            end
            stt_pkg::K_TRANS: begin
              res_seg_nxt = found_r;
              res_ofs_nxt = cmd_r.linear_address - {found_r, 4'b0000};
              state_nxt   = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Move entries up one place, top first: read dst-1, write dst next cycle.
        if (dst_r > pos_r) begin
          rd_addr  = dst_r - IW'(1);
          didx_nxt = dst_r;
          dvld_nxt = 1'b1;
          dst_nxt  = dst_r - IW'(1);
        end else begin
          dvld_nxt = 1'b0;
        end

        if (dvld_r) begin
          we = 1'b1;
          wa = didx_r;
          wd = rdata_r;
        end else if (dst_r == pos_r) begin
          we        = 1'b1;
          wa        = pos_r;
          wd        = '{seg: cmd_r.segment, lo: stt_pkg::RANGE_EMPTY_LO,
                        hi: stt_pkg::RANGE_EMPTY_HI};
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    didx_r       <= didx_nxt;
    pos_r        <= pos_nxt;
    dst_r        <= dst_nxt;
    found_r      <= found_nxt;
    cmd_r        <= cmd_nxt;
    res_status_r <= res_status_nxt;
    res_seg_r    <= res_seg_nxt;
    res_ofs_r    <= res_ofs_nxt;
    res_lo_r     <= res_lo_nxt;
    res_hi_r     <= res_hi_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_seg_r    <= res_seg_r;
      out_ofs_r    <= res_ofs_r;
      out_lo_r     <= res_lo_r;
      out_hi_r     <= res_hi_r;
    end
  end

  // Segment table storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0000, out_hi_r, out_lo_r, out_ofs_r, out_seg_r};
  assign stat.idle  = (state_r == S_IDLE);
  assign stat.count = count_r;

endmodule

@@ rtl/segment_table_translate_unit.sv @@
// Flow: an accepted word waits in the queue until the engine is idle; the engine walks the table
// (an unused code skips the walk) and registers the result word. An add that inserts then shifts
// entries up, starting where the search stopped. The engine works on one word at a time and may
// wait on out_tready; a two-word queue keeps taking input meanwhile, as long as it has room.
// Reset: synchronous, active-low rst_n empties the table and the queue; table contents
// are not cleared, since only entries below the fill count are ever read.
module segment_table_translate_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input word.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata fields, lowest bit up: segment [15:0], offset [31:16],
  // linear_address [51:32], zero pad [55:52].
  input  logic [stt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser fields: operation [1:0].
  input  logic [1:0]                        in_tuser,
  // Result word.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata fields, lowest bit up: result_segment [15:0], result_offset [35:16],
  // range_low [51:36], range_high [67:52], zero pad [71:68].
  output logic [stt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser fields: status [1:0].
  output logic [1:0]                        out_tuser
);

  // The front decodes each input word into a command and holds it in a short
  // queue; the engine pops one command at a time, walks the sorted table one
  // entry per cycle, and parks its result in an output register so the next
  // command can start as soon as that register is free.

  logic               cmd_valid;
  stt_pkg::cmd_t      cmd;
  logic               cmd_pop;
  stt_pkg::eng_stat_t eng_stat;

  stt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  stt_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .stat       (eng_stat)
  );

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    eng_stat.count <= stt_pkg::CNT_W'(stt_pkg::MAX_SEGMENTS))
    else $error("segment count exceeds table size");

  // The fill count only holds or grows by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (eng_stat.count == $past(eng_stat.count)) ||
             (eng_stat.count == $past(eng_stat.count) + stt_pkg::CNT_W'(1)))
    else $error("segment count changed by more than one");

  // A command leaves the queue only when the engine is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> eng_stat.idle)
    else $error("command popped while engine busy");

  // A table-full result is only reported while the table is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == stt_pkg::ST_FULL)) |->
      (eng_stat.count == stt_pkg::CNT_W'(stt_pkg::MAX_SEGMENTS)))
    else $error("table full reported with free entries");

endmodule

@@ sim/testbench.sv @@
module testbench;

  // One result word, unpacked from out_tuser and out_tdata.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] segment;
    logic [19:0] offset;
    logic [15:0] range_low;
    logic [15:0] range_high;
  } seg_result_t;

  // One command word waiting to be driven. When drain_first is set, the driver holds it back
  // until every result of the words before it has come back.
  typedef struct {
    stt_pkg::kind_t kind;
    logic [15:0]    segment;
    logic [15:0]    offset;
    logic [19:0]    linear_address;
    bit             drain_first;
  } seg_cmd_t;

  // Cycle window in which neither side inserts idle cycles, so the block runs back to back.
  localparam int QUIET_FROM = 30000;
  localparam int QUIET_TO   = 42000;
  localparam int RANDOM_WORDS = 950;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // Fields from the lowest bit up: segment, offset, linear_address, zero pad.
  logic [stt_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  // Fields: operation.
  logic [1:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // Fields from the lowest bit up: result_segment, result_offset, range_low, range_high, pad.
  logic [stt_pkg::OUT_TDATA_W-1:0] out_tdata;
  // Fields: status.
  logic [1:0]                      out_tuser;

  segment_table_translate_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reset is held low at the start and released on a falling edge, like every other input.
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Safety net: a stuck handshake ends the run here.
  initial begin
    #20000000;
    $display("[segment_table_translate_unit] ERROR");
    $finish;
  end

  seg_cmd_t    cmd_backlog[$];
  seg_result_t expected_results[$];

  // Shadow copy of the segment table, kept sorted by segment value.
  stt_pkg::entry_t shadow_table [stt_pkg::MAX_SEGMENTS];
  int              shadow_count = 0;

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  in_fire = 1'b0;
  int  kind_taken [4];
  int  words_checked = 0;
  int  full_seen = 0;
  int  dup_seen = 0;
  int  unknown_seen = 0;

  // Applies one command to the shadow table and returns the result word it must produce.
  function automatic seg_result_t predict_segment_result(stt_pkg::kind_t kind, logic [15:0] seg,
                                                         logic [15:0] ofs, logic [19:0] addr);
    seg_result_t r;
    int          pos;
    int          k;
    logic [15:0] found;
    r = '0;
    pos = 0;
    case (kind)
      stt_pkg::K_ADD: begin
        r.segment = seg;
        while (pos < shadow_count && shadow_table[pos].seg < seg) pos++;
        // A duplicate is reported even when the table is full.
        if (pos < shadow_count && shadow_table[pos].seg == seg) begin
          r.status = stt_pkg::ST_DUP;
        end else if (shadow_count >= stt_pkg::MAX_SEGMENTS) begin
          r.status = stt_pkg::ST_FULL;
        end else begin
          for (k = shadow_count; k > pos; k--) shadow_table[k] = shadow_table[k - 1];
          shadow_table[pos].seg = seg;
          shadow_table[pos].lo  = stt_pkg::RANGE_EMPTY_LO;
          shadow_table[pos].hi  = stt_pkg::RANGE_EMPTY_HI;
          shadow_count++;
          r.status = stt_pkg::ST_DONE;
        end
      end
      stt_pkg::K_REG: begin
        r.segment = seg;
        while (pos < shadow_count && shadow_table[pos].seg != seg) pos++;
        if (pos == shadow_count) begin
          r.status = stt_pkg::ST_UNKNOWN;
        end else begin
          if (ofs < shadow_table[pos].lo) shadow_table[pos].lo = ofs;
          if (ofs > shadow_table[pos].hi) shadow_table[pos].hi = ofs;
          r.status     = stt_pkg::ST_DONE;
          r.range_low  = shadow_table[pos].lo;
          r.range_high = shadow_table[pos].hi;
        end
      end
      stt_pkg::K_TRANS: begin
        // Highest base not above the address; segment 0 when no base qualifies.
        found = '0;
        while (pos < shadow_count && {shadow_table[pos].seg, 4'h0} <= addr) begin
          found = shadow_table[pos].seg;
          pos++;
        end
        r.segment = found;
        r.offset  = addr - {found, 4'h0};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic compare_field(string name, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Sampling side: records every accepted command word, predicts its result, and checks every
  // result word against the oldest prediction. All sampling happens at the rising edge.
  always @(posedge clk) begin : word_monitor
    seg_result_t want;
    seg_result_t got;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_segment_result(stt_pkg::kind_t'(in_tuser),
                                                          in_tdata[15:0], in_tdata[31:16],
                                                          in_tdata[51:32]));
        kind_taken[in_tuser]++;
      end
      if (out_tvalid && out_tready) begin
        got.status     = out_tuser;
        got.segment    = out_tdata[15:0];
        got.offset     = out_tdata[35:16];
        got.range_low  = out_tdata[51:36];
        got.range_high = out_tdata[67:52];
        if (expected_results.size() == 0) begin
          $error("result word with no command waiting for it");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("result_segment", want.segment, got.segment);
          compare_field("result_offset", want.offset, got.offset);
          compare_field("range_low", want.range_low, got.range_low);
          compare_field("range_high", want.range_high, got.range_high);
          words_checked++;
          if (want.status == stt_pkg::ST_FULL) full_seen++;
          if (want.status == stt_pkg::ST_DUP) dup_seen++;
          if (want.status == stt_pkg::ST_UNKNOWN) unknown_seen++;
        end
      end
    end
  end

  // Driving side: all inputs change on the falling edge. A word stays on the bus until it is
  // taken; only then does the driver decide between the next word and an idle cycle. Inside
  // the quiet window both sides run without gaps.
  always @(negedge clk) begin : word_driver
    seg_cmd_t c;
    bit       quiet;
    quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= 19);
      if (!in_tvalid || in_fire) begin
        if (cmd_backlog.size() == 0 || (!quiet && $urandom_range(0, 99) < 19) ||
            (cmd_backlog[0].drain_first && expected_results.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          c = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'h0, c.linear_address, c.offset, c.segment};
          in_tuser  <= c.kind;
        end
      end
    end
  end

  // Segments the stimulus has asked to add, as long as the table has room for them. Register
  // and translate words mostly aim at these so that they hit live entries.
  logic [15:0] gen_segs[$];
  bit          gen_known[logic [15:0]];

  task automatic queue_cmd(stt_pkg::kind_t kind, logic [15:0] seg, logic [15:0] ofs,
                           logic [19:0] addr, bit drain);
    seg_cmd_t c;
    c.kind           = kind;
    c.segment        = seg;
    c.offset         = ofs;
    c.linear_address = addr;
    c.drain_first    = drain;
    cmd_backlog.push_back(c);
    if (kind == stt_pkg::K_ADD && !gen_known.exists(seg) &&
        gen_segs.size() < stt_pkg::MAX_SEGMENTS) begin
      gen_known[seg] = 1'b1;
      gen_segs.push_back(seg);
    end
  endtask

  initial begin : stimulus
    int             n;
    int             sel;
    stt_pkg::kind_t kind;
    logic [15:0]    seg;
    logic [15:0]    ofs;
    logic [15:0]    s;
    logic [19:0]    addr;
    logic [19:0]    base;

    // Directed words. The empty table comes first: translations fall back to segment 0
    // and a register finds nothing.
    queue_cmd(stt_pkg::K_TRANS, 16'h0000, 16'h0000, 20'h00000, 1'b0);
    queue_cmd(stt_pkg::K_TRANS, 16'hffff, 16'hffff, 20'hfffff, 1'b0);
    queue_cmd(stt_pkg::K_REG,   16'h1234, 16'h5678, 20'h00000, 1'b0);
    queue_cmd(stt_pkg::K_NOP,   16'h5a5a, 16'ha5a5, 20'h3c3c3, 1'b0);
    queue_cmd(stt_pkg::K_ADD,   16'h1000, 16'h0000, 20'h00000, 1'b0);
    // Address below the only base: still segment 0 with the address as offset.
    queue_cmd(stt_pkg::K_TRANS, 16'h0000, 16'h0000, 20'h00fff, 1'b0);
    queue_cmd(stt_pkg::K_ADD,   16'h0000, 16'hffff, 20'hfffff, 1'b0);
    queue_cmd(stt_pkg::K_ADD,   16'hffff, 16'h0000, 20'h00000, 1'b0);
    queue_cmd(stt_pkg::K_ADD,   16'h1000, 16'h1111, 20'h11111, 1'b0);
    queue_cmd(stt_pkg::K_ADD,   16'h8000, 16'h0000, 20'h00000, 1'b0);
    // Range of a fresh entry widened from both ends, plus a single-point range.
    queue_cmd(stt_pkg::K_REG,   16'h1000, 16'h0000, 20'h00000, 1'b0);
    queue_cmd(stt_pkg::K_REG,   16'h1000, 16'hffff, 20'h00000, 1'b0);
    queue_cmd(stt_pkg::K_REG,   16'hffff, 16'h8000, 20'hfffff, 1'b0);
    queue_cmd(stt_pkg::K_REG,   16'h0001, 16'hffff, 20'h00000, 1'b0);
    queue_cmd(stt_pkg::K_TRANS, 16'h0000, 16'h0000, 20'h0000f, 1'b0);
    queue_cmd(stt_pkg::K_TRANS, 16'h0000, 16'h0000, 20'hfffff, 1'b0);
    queue_cmd(stt_pkg::K_TRANS, 16'h0000, 16'h0000, 20'hffff0, 1'b0);
    queue_cmd(stt_pkg::K_TRANS, 16'h0000, 16'h0000, 20'h0ffff, 1'b0);
    queue_cmd(stt_pkg::K_TRANS, 16'h0000, 16'h0000, 20'h10000, 1'b0);
    // Offset past 16 bits when the next base is far away.
    queue_cmd(stt_pkg::K_TRANS, 16'h0000, 16'h0000, 20'h7ffff, 1'b0);
    queue_cmd(stt_pkg::K_NOP,   16'hffff, 16'hffff, 20'hfffff, 1'b0);
    queue_cmd(stt_pkg::K_ADD,   16'h0000, 16'h0000, 20'h00000, 1'b0);

    // Random words. Adds are kept rare enough that the table fills about halfway through,
    // so both the growing and the full table see plenty of traffic. Twice the driver waits
    // for the block to drain before going on.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      sel  = $urandom_range(0, 99);
      seg  = 16'($urandom);
      ofs  = 16'($urandom);
      addr = 20'($urandom);
      if (sel < 14) begin
        kind = stt_pkg::K_ADD;
        if (gen_segs.size() > 0 && $urandom_range(0, 4) == 0)
          seg = gen_segs[$urandom_range(0, gen_segs.size() - 1)];
      end else if (sel < 48) begin
        kind = stt_pkg::K_REG;
        if (gen_segs.size() > 0 && $urandom_range(0, 99) < 85)
          seg = gen_segs[$urandom_range(0, gen_segs.size() - 1)];
        case ($urandom_range(0, 9))
          0: ofs = 16'h0000;
          1: ofs = 16'hffff;
          default: ;
        endcase
      end else if (sel < 95) begin
        kind = stt_pkg::K_TRANS;
        if (gen_segs.size() > 0 && $urandom_range(0, 1) == 1) begin
          // Aim at the edges around a live base.
          s    = gen_segs[$urandom_range(0, gen_segs.size() - 1)];
          base = {s, 4'h0};
          case ($urandom_range(0, 3))
            0: addr = base;
            1: addr = base - 20'd1;
            2: addr = base + 20'($urandom_range(0, 255));
            default: addr = base + {4'h0, ofs};
          endcase
        end
      end else begin
        kind = stt_pkg::K_NOP;
      end
      queue_cmd(kind, seg, ofs, addr, (n == 0) || (n == 600));
    end

    while (cmd_backlog.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // Give stray words time to come out of the block.
    repeat (200) @(posedge clk);

    $display("Checked %0d result words: %0d adds, %0d registers, %0d translates, %0d unused codes.",
             words_checked, kind_taken[stt_pkg::K_ADD], kind_taken[stt_pkg::K_REG],
             kind_taken[stt_pkg::K_TRANS], kind_taken[stt_pkg::K_NOP]);
    $display("Table ended with %0d segments; %0d full, %0d duplicate, %0d unknown-segment replies.",
             shadow_count, full_seen, dup_seen, unknown_seen);
    if (fail_count == 0) begin
      $display("[segment_table_translate_unit] OK");
    end else begin
      $display("[segment_table_translate_unit] ERROR");
    end
    $finish;
  end

endmodule
